// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
// Needs nothing else; each macro clocks on a rising edge and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold in the same cycle.
`define AVFP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that implies a property in the next cycle.
`define AVFP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/core/avfp_pkg.sv
// Shared types and constants of the Avro float array field parser.
// Used by the decoder, the output stage, the top level and the checker.
`default_nettype none

package avfp_pkg;

	// Result kinds.
	typedef enum logic [2:0] {
		KIND_ELEM    = 3'd0,
		KIND_MISSING = 3'd1,
		KIND_END     = 3'd2,
		KIND_NULL    = 3'd3,
		KIND_ERROR   = 3'd4
	} kind_t;

	// Parsing position within the field.
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_COUNT = 3'd1,
		PH_SIZE  = 3'd2,
		PH_ETAG  = 3'd3,
		PH_EDATA = 3'd4
	} phase_t;

	// Configuration register indexes.
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] CFG_FIELD_OPTIONAL    = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_ELEMENT_OPTIONAL  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_ELEMENT_IS_DOUBLE = 2'd2;

	// Union tag values.
	localparam logic [7:0] TAG_NULL    = 8'd0;
	localparam logic [7:0] TAG_PRESENT = 8'd2;

	// Varint and element lengths in bytes.
	localparam logic [3:0] VarintMaxBytes = 4'd10;
	localparam logic [3:0] FloatBytes     = 4'd4;
	localparam logic [3:0] DoubleBytes    = 4'd8;

	typedef struct packed {
		logic field_optional;
		logic element_optional;
		logic element_is_double;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic [63:0] varint_acc;
		logic [3:0]  varint_bytes;
		logic [63:0] elements_left;
		logic [2:0]  byte_pos;
		logic [63:0] element_bits;
	} parse_state_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [63:0] value;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/core/avro_float_array_field_parser_core.sv
// Avro float/double array field parser, top level.
// Holds the input register and the configuration registers; uses avfp_pkg,
// avfp_decode and avfp_out_stage.
//
// Usage:
//   Bytes of one encoded array field enter on in_valid/in_stall/in_byte, one
//   byte per item. Results leave on out_valid/out_stall with kind and
//   value_bits; a byte yields zero or one result.
//   The user writes the three configuration registers (cfg_we, cfg_index, cfg_data)
//   only while no item is in flight; the block does not enforce it. Index 3 is ignored.
// Flow:
//   A byte accepted into the input register is decoded from it; the decoder
//   state and the result register both take it when it moves on, and the
//   result is shown from the result register. One byte per cycle is sustained
//   while the output is not stalled, as the decoder state updates once per byte.
// Reset:
//   arst_n clears the parsing state, the configuration and both valid bits.
// Stall:
//   While a result is stalled, the input register still takes a byte if it is
//   empty; a held byte then waits, and in_stall rises until the result leaves.
`default_nettype none

module avro_float_array_field_parser_core
	import avfp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         in_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              kind,
	output logic [63:0]             value_bits,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [0:0]         cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       fire;
	result_t    res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIELD_OPTIONAL:    cfg_q.field_optional    <= cfg_data[0];
				CFG_ELEMENT_OPTIONAL:  cfg_q.element_optional  <= cfg_data[0];
				CFG_ELEMENT_IS_DOUBLE: cfg_q.element_is_double <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register: it stalls only when holding a byte that cannot move on.
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	avfp_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.data   (byte_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	avfp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.res        (res),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.value_bits (value_bits)
	);

endmodule

`default_nettype wire

// File: rtl/core/avfp_decode.sv
// Byte decoder of the parser: holds the parsing state and turns one byte into
// at most one result. Depends on avfp_pkg for the state, config and result types.
`default_nettype none

module avfp_decode
	import avfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [7:0]  data,
	input  wire cfg_t        cfg,
	output result_t          res
);

	parse_state_t st_q;
	parse_state_t st_nxt;

	logic [63:0] varint_or;
	logic [3:0]  bytes_inc;
	logic        v_done;
	logic        v_ovf;
	logic        do_count;
	logic [63:0] elem_or;
	logic [3:0]  pos_inc;
	logic [3:0]  elem_len;
	logic [6:0]  vshift;

	// Shared varint and element byte arithmetic.
	always_comb begin
		vshift    = 7'(st_q.varint_bytes) * 7'd7;
		varint_or = st_q.varint_acc | ({56'd0, 1'b0, data[6:0]} << vshift);
		bytes_inc = st_q.varint_bytes + 4'd1;
		v_done    = !data[7];
		v_ovf     = data[7] && (bytes_inc >= VarintMaxBytes);
		elem_or   = st_q.element_bits | ({56'd0, data} << {st_q.byte_pos, 3'b000});
		pos_inc   = {1'b0, st_q.byte_pos} + 4'd1;
		elem_len  = cfg.element_is_double ? DoubleBytes : FloatBytes;
	end

	// Next state and result for the byte in hand.
	always_comb begin
		st_nxt   = st_q;
		res      = '0;
		do_count = 1'b0;
		unique case (st_q.phase)
			PH_IDLE: begin
				if (!cfg.field_optional) begin
					do_count = 1'b1;
				end else if (data == TAG_NULL) begin
					res = '{valid: 1'b1, kind: KIND_NULL, value: 64'd0};
				end else if (data == TAG_PRESENT) begin
					st_nxt.phase = PH_COUNT;
				end else begin
					st_nxt = '0;
					res    = '{valid: 1'b1, kind: KIND_ERROR, value: 64'd0};
				end
			end
			PH_COUNT: begin
				do_count = 1'b1;
			end
			PH_SIZE: begin
				if (v_ovf) begin
					st_nxt = '0;
					res    = '{valid: 1'b1, kind: KIND_ERROR, value: 64'd0};
				end else if (!v_done) begin
					st_nxt.varint_acc   = varint_or;
					st_nxt.varint_bytes = bytes_inc;
				end else begin
					st_nxt.varint_acc   = 64'd0;
					st_nxt.varint_bytes = 4'd0;
					st_nxt.byte_pos     = 3'd0;
					st_nxt.element_bits = 64'd0;
					st_nxt.phase        = cfg.element_optional ? PH_ETAG : PH_EDATA;
				end
			end
			PH_ETAG: begin
				if (data == TAG_NULL) begin
					res = '{valid: 1'b1, kind: KIND_MISSING, value: 64'd0};
					st_nxt.elements_left = st_q.elements_left - 64'd1;
					if (st_q.elements_left == 64'd1) begin
						st_nxt.phase = PH_COUNT;
					end else begin
						st_nxt.byte_pos     = 3'd0;
						st_nxt.element_bits = 64'd0;
						st_nxt.phase        = cfg.element_optional ? PH_ETAG : PH_EDATA;
					end
				end else if (data == TAG_PRESENT) begin
					st_nxt.phase = PH_EDATA;
				end else begin
					st_nxt = '0;
					res    = '{valid: 1'b1, kind: KIND_ERROR, value: 64'd0};
				end
			end
			PH_EDATA: begin
				st_nxt.element_bits = elem_or;
				if (pos_inc >= elem_len) begin
					res = '{valid: 1'b1, kind: KIND_ELEM, value: elem_or};
					st_nxt.elements_left = st_q.elements_left - 64'd1;
					if (st_q.elements_left == 64'd1) begin
						st_nxt.phase = PH_COUNT;
					end else begin
						st_nxt.byte_pos     = 3'd0;
						st_nxt.element_bits = 64'd0;
						st_nxt.phase        = cfg.element_optional ? PH_ETAG : PH_EDATA;
					end
				end else begin
					st_nxt.byte_pos = pos_inc[2:0];
				end
			end
			default: begin
				st_nxt = '0;
				res    = '{valid: 1'b1, kind: KIND_ERROR, value: 64'd0};
			end
		endcase

		// Block count varint, entered from idle without a field tag or from the count phase.
		if (do_count) begin
			if (v_ovf) begin
				st_nxt = '0;
				res    = '{valid: 1'b1, kind: KIND_ERROR, value: 64'd0};
			end else if (!v_done) begin
				st_nxt.phase        = PH_COUNT;
				st_nxt.varint_acc   = varint_or;
				st_nxt.varint_bytes = bytes_inc;
			end else begin
				st_nxt.varint_acc   = 64'd0;
				st_nxt.varint_bytes = 4'd0;
				if (!varint_or[0]) begin
					if (varint_or[63:1] == 63'd0) begin
						st_nxt = '0;
						res    = '{valid: 1'b1, kind: KIND_END, value: 64'd0};
					end else begin
						st_nxt.elements_left = {1'b0, varint_or[63:1]};
						st_nxt.byte_pos      = 3'd0;
						st_nxt.element_bits  = 64'd0;
						st_nxt.phase = cfg.element_optional ? PH_ETAG : PH_EDATA;
					end
				end else begin
					// A negative count: take its magnitude and skip the byte size.
					st_nxt.elements_left = {1'b0, varint_or[63:1]} + 64'd1;
					st_nxt.phase         = PH_SIZE;
				end
			end
		end
	end

	// State register, updated only when a byte is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/avfp_out_stage.sv
// Result register of the parser with its valid/stall handshake.
// Depends on avfp_pkg for the result type.
`default_nettype none

module avfp_out_stage
	import avfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire result_t     res,
	output logic             advance,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [63:0]      value_bits
);

	logic        valid_q;
	kind_t       kind_q;
	logic [63:0] value_q;

	// The register may take a new item when empty or when its item leaves now.
	assign advance = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= fire && res.valid;
		end
	end

	// Payload holds while stalled.
	always_ff @(posedge clk) begin
		if (advance && fire && res.valid) begin
			kind_q  <= res.kind;
			value_q <= res.value;
		end
	end

	assign out_valid  = valid_q;
	assign kind       = kind_q;
	assign value_bits = value_q;

endmodule

`default_nettype wire

// File: rtl/core/avfp_checker.sv
// Port-level checks of the parser top level, attached by a bind below.
// Depends on avfp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module avfp_checker
	import avfp_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [2:0]         kind,
	input wire logic [63:0]        value_bits
);

	// A stalled result holds.
	`AVFP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(kind) && $stable(value_bits), "stalled result changed")

	// Only element results carry bits.
	`AVFP_ASSERT(a_zero_bits, clk, arst_n, !out_valid || kind == KIND_ELEM || value_bits == 64'd0, "non-element result with bits")

	// Kind codes stay within the defined set.
	`AVFP_ASSERT(a_kind_range, clk, arst_n, !out_valid || kind <= KIND_ERROR, "undefined result kind")

	// The input side stalls only behind a stalled result.
	`AVFP_ASSERT(a_stall_cause, clk, arst_n, !in_stall || (out_valid && out_stall), "input stalled without output back-pressure")

endmodule

bind avro_float_array_field_parser_core avfp_checker u_avfp_checker (.*);

`default_nettype wire

// File: dv/tb_avro_float_array_field_parser_core.sv
// Self-checking testbench for the Avro float/double array field parser core.
// Depends on avfp_pkg and avro_float_array_field_parser_core; a built-in parser
// model predicts every result and a monitor checks the results in order.
`default_nettype none

module tb_avro_float_array_field_parser_core;
	timeunit 1ns;
	timeprecision 1ps;

	import avfp_pkg::*;

	localparam int unsigned RunLimit     = 200000;
	localparam int unsigned SettleCycles = 8;
	localparam int unsigned HoldCycles   = 300;
	localparam int unsigned PhaseItems   = 105;

	// One decoded record as the block should give it.
	typedef struct packed {
		kind_t       kind;
		logic [63:0] value;
	} field_rec_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [7:0]          in_byte    = 8'd0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [2:0]          kind;
	logic [63:0]         value_bits;
	logic                cfg_we     = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index  = '0;
	logic [0:0]          cfg_data   = 1'b0;

	// Bytes waiting to be offered, and records still owed by the block.
	logic [7:0]   byte_stream[$];
	field_rec_t   decoded_due[$];
	logic [7:0]   next_bytes[$];

	// Parser model state: the live copy follows accepted items, the other
	// one runs ahead while a phase's bytes are chosen.
	parse_state_t parser    = '0;
	parse_state_t plan_st   = '0;
	cfg_t         cfg_now   = '0;
	field_rec_t   new_rec;
	field_rec_t   head_rec;

	int unsigned  send_idle_pct  = 0;
	int unsigned  recv_stall_pct = 0;
	int unsigned  hold_req       = 0;
	int unsigned  hold_ack       = 0;
	int unsigned  hold_left      = 0;
	int unsigned  mismatches     = 0;
	int unsigned  cycles         = 0;
	int unsigned  idle_tx[4]     = '{0, 74, 0, 16};
	int unsigned  idle_rx[4]     = '{0, 0, 74, 16};

	avro_float_array_field_parser_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.value_bits (value_bits),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Queue appends: planned bytes, bytes to send and records owed.
	function automatic void plan_byte(input logic [7:0] b);
		next_bytes = {next_bytes, b};
	endfunction

	function automatic void send_byte(input logic [7:0] b);
		byte_stream = {byte_stream, b};
	endfunction

	function automatic void owe_record(input field_rec_t r);
		decoded_due = {decoded_due, r};
	endfunction

	// Fresh element: optional tag first, else straight to the data bytes.
	function automatic void enter_element(inout parse_state_t s, input cfg_t c);
		s.byte_pos = '0;
		s.element_bits = '0;
		s.phase = c.element_optional ? PH_ETAG : PH_EDATA;
	endfunction

	function automatic void element_finished(inout parse_state_t s, input cfg_t c);
		s.elements_left = s.elements_left - 64'd1;
		if (s.elements_left == 64'd0) begin
			s.phase = PH_COUNT;
		end else begin
			enter_element(s, c);
		end
	endfunction

	// Adds one LEB128 byte: 1 when the varint is complete, 0 when more bytes
	// follow, -1 when it runs past the longest allowed length.
	function automatic int varint_add(inout parse_state_t s, input logic [7:0] b);
		int unsigned sh;
		sh = 7 * s.varint_bytes;
		if (sh < 64) begin
			s.varint_acc = s.varint_acc | (64'(b[6:0]) << sh);
		end
		s.varint_bytes = s.varint_bytes + 4'd1;
		if (!b[7]) begin
			return 1;
		end
		if (s.varint_bytes >= VarintMaxBytes) begin
			return -1;
		end
		return 0;
	endfunction

	// Block count byte; a zero count ends the array, a negative one is
	// followed by a block size that is skipped.
	function automatic bit count_add(inout parse_state_t s, input cfg_t c,
			input logic [7:0] b, inout field_rec_t r);
		int st;
		logic [63:0] v;
		st = varint_add(s, b);
		if (st < 0) begin
			s = '0;
			r.kind = KIND_ERROR;
			return 1'b1;
		end
		if (st == 0) begin
			return 1'b0;
		end
		v = s.varint_acc;
		s.varint_acc = '0;
		s.varint_bytes = '0;
		if (!v[0]) begin
			if (v[63:1] == 63'd0) begin
				s = '0;
				r.kind = KIND_END;
				return 1'b1;
			end
			s.elements_left = {1'b0, v[63:1]};
			enter_element(s, c);
		end else begin
			s.elements_left = {1'b0, v[63:1]} + 64'd1;
			s.phase = PH_SIZE;
		end
		return 1'b0;
	endfunction

	// Advances the parser model by one byte; returns 1 when a record results.
	function automatic bit parse_byte(inout parse_state_t s, input cfg_t c,
			input logic [7:0] b, output field_rec_t r);
		int st;
		logic [3:0] len;
		r.kind = KIND_ERROR;
		r.value = '0;
		case (s.phase)
			PH_IDLE: begin
				if (!c.field_optional) begin
					s.phase = PH_COUNT;
					return count_add(s, c, b, r);
				end
				if (b == TAG_NULL) begin
					r.kind = KIND_NULL;
					return 1'b1;
				end
				if (b == TAG_PRESENT) begin
					s.phase = PH_COUNT;
					return 1'b0;
				end
				s = '0;
				return 1'b1;
			end
			PH_COUNT: begin
				return count_add(s, c, b, r);
			end
			PH_SIZE: begin
				st = varint_add(s, b);
				if (st < 0) begin
					s = '0;
					return 1'b1;
				end
				if (st > 0) begin
					s.varint_acc = '0;
					s.varint_bytes = '0;
					enter_element(s, c);
				end
				return 1'b0;
			end
			PH_ETAG: begin
				if (b == TAG_NULL) begin
					element_finished(s, c);
					r.kind = KIND_MISSING;
					return 1'b1;
				end
				if (b == TAG_PRESENT) begin
					s.phase = PH_EDATA;
					return 1'b0;
				end
				s = '0;
				return 1'b1;
			end
			PH_EDATA: begin
				len = c.element_is_double ? DoubleBytes : FloatBytes;
				s.element_bits = s.element_bits | (64'(b) << (8 * s.byte_pos));
				if ({1'b0, s.byte_pos} + 4'd1 >= len) begin
					r.kind = KIND_ELEM;
					r.value = s.element_bits;
					element_finished(s, c);
					return 1'b1;
				end
				s.byte_pos = s.byte_pos + 3'd1;
				return 1'b0;
			end
			default: begin
				s = '0;
				return 1'b1;
			end
		endcase
	endfunction

	// LEB128 encoding, optionally padded with redundant continuation bytes.
	function automatic void queue_varint(input logic [63:0] v, input int pad);
		while ((v >> 7) != 64'd0 || pad > 0) begin
			plan_byte({1'b1, v[6:0]});
			if ((v >> 7) == 64'd0) begin
				pad--;
			end
			v = v >> 7;
		end
		plan_byte({1'b0, v[6:0]});
	endfunction

	// Picks a block count: mostly small ones of either sign, some ends, some
	// overlong varints, and huge counts only where element tags let the
	// field be broken off again.
	function automatic void plan_count();
		int unsigned pick;
		int unsigned n;
		int pad;
		pick = $urandom_range(99);
		n = $urandom_range(6, 1);
		pad = ($urandom_range(4) == 0) ? int'($urandom_range(3, 1)) : 0;
		if (pick < 20) begin
			queue_varint(64'd0, pad);
		end else if (pick < 58) begin
			queue_varint(64'(2 * n), pad);
		end else if (pick < 90) begin
			queue_varint(64'(2 * n - 1), pad);
		end else if (pick < 96 || !cfg_now.element_optional) begin
			repeat (VarintMaxBytes) plan_byte({1'b1, 7'($urandom)});
		end else if ($urandom_range(1) == 0) begin
			queue_varint(64'hFFFF_FFFF_FFFF_FFFF, 0);
		end else begin
			queue_varint({$urandom, $urandom}, 0);
		end
	endfunction

	// Chooses the next bytes from where the model parser stands, so that
	// most of the stream is a well-formed field with random content.
	function automatic void plan_more();
		int unsigned pick;
		pick = $urandom_range(99);
		case (plan_st.phase)
			PH_IDLE: begin
				if (!cfg_now.field_optional) begin
					plan_count();
				end else if (pick < 70) begin
					plan_byte(TAG_PRESENT);
				end else if (pick < 88) begin
					plan_byte(TAG_NULL);
				end else begin
					plan_byte(8'($urandom));
				end
			end
			PH_COUNT: begin
				plan_count();
			end
			PH_SIZE: begin
				queue_varint(64'($urandom_range(20000)), pick < 10 ? 1 : 0);
			end
			PH_ETAG: begin
				if (pick < 72) begin
					plan_byte(TAG_PRESENT);
				end else if (pick < 94) begin
					plan_byte(TAG_NULL);
				end else begin
					plan_byte(8'($urandom));
				end
			end
			default: begin
				if (pick < 10) begin
					plan_byte(8'h00);
				end else if (pick < 20) begin
					plan_byte(8'hFF);
				end else begin
					plan_byte(8'($urandom));
				end
			end
		endcase
	endfunction

	// Queues one phase of random bytes, starting from the drained live state.
	task automatic plan_stream(input int unsigned count);
		field_rec_t r;
		logic [7:0] b;
		plan_st = parser;
		next_bytes.delete();
		repeat (count) begin
			if ($urandom_range(99) < 3) begin
				b = 8'($urandom);
				next_bytes.delete();
			end else begin
				if (next_bytes.size() == 0) begin
					plan_more();
				end
				b = next_bytes.pop_front();
			end
			send_byte(b);
			// A field that ended or broke off leaves the rest of a plan stale.
			if (parse_byte(plan_st, cfg_now, b, r) && r.kind != KIND_ELEM
					&& r.kind != KIND_MISSING) begin
				next_bytes.delete();
			end
		end
	endtask

	// Waits until every item went in and every record came out, then lets
	// bytes that give no record work through the block.
	task automatic settle();
		@(negedge clk);
		while (byte_stream.size() != 0 || in_valid || decoded_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FIELD_OPTIONAL:    cfg_now.field_optional = v;
			CFG_ELEMENT_OPTIONAL:  cfg_now.element_optional = v;
			CFG_ELEMENT_IS_DOUBLE: cfg_now.element_is_double = v;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_cfg(input cfg_t c);
		write_reg(CFG_FIELD_OPTIONAL, c.field_optional);
		write_reg(CFG_ELEMENT_OPTIONAL, c.element_optional);
		write_reg(CFG_ELEMENT_IS_DOUBLE, c.element_is_double);
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Sender: offers queued bytes with random gaps and predicts each
	// accepted item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (parse_byte(parser, cfg_now, in_byte, new_rec)) begin
					owe_record(new_rec);
				end
			end
			if (!in_valid || !in_stall) begin
				if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_byte <= byte_stream.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= HoldCycles;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Each record that leaves is checked against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_due.size() == 0) begin
				report_mismatch($sformatf("unexpected record kind %0d value %h",
					kind, value_bits));
			end else begin
				head_rec = decoded_due.pop_front();
				if (kind !== head_rec.kind) begin
					report_mismatch($sformatf("kind %0d, wanted %0d", kind, head_rec.kind));
				end
				if (value_bits !== head_rec.value) begin
					report_mismatch($sformatf("value_bits %h, wanted %h", value_bits,
						head_rec.value));
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RunLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Stimulus: directed fields first, then random phases over every setting.
	initial begin
		cfg_t c;
		int unsigned sel;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Field without a tag: one double element left with five of its eight bytes.
		write_reg(CFG_ELEMENT_IS_DOUBLE, 1'b1);
		send_byte(8'h02);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		settle();

		// Switching to floats mid-element completes it on the next byte.
		// Then an end, a null field, a negative count with a skipped size,
		// a missing element, the largest negative count and a bad tag.
		c = '0;
		c.field_optional = 1'b1;
		c.element_optional = 1'b1;
		apply_cfg(c);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(TAG_NULL);
		send_byte(TAG_PRESENT);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(TAG_NULL);
		repeat (9) send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h09);
		settle();

		// Random phases; each phase ends wherever its stream stops, so the
		// next setting often takes effect mid-field.
		for (int p = 0; p < 8; p++) begin
			apply_cfg(cfg_t'(3'(p)));
			sel = (p + p / 4) % 4;
			send_idle_pct = idle_tx[sel];
			recv_stall_pct = idle_rx[sel];
			if (p == 0) begin
				hold_req++;
			end
			plan_stream(PhaseItems);
			settle();
		end

		if (mismatches == 0 && decoded_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/avfp_pkg.sv
rtl/core/avfp_decode.sv
rtl/core/avfp_out_stage.sv
rtl/core/avro_float_array_field_parser_core.sv
rtl/core/avfp_checker.sv
dv/tb_avro_float_array_field_parser_core.sv
